>>> rtl/core/vnks_pkg.sv
// ----------------------------------------------------------------------------
// vnks_pkg
// Types, keyword table and verdict codes shared by the keyword screen.
// ----------------------------------------------------------------------------
package vnks_pkg;

  localparam int KW_COUNT = 16;
  localparam int KW_ROW   = 24;
  localparam int KW_IDX_W = $clog2(KW_COUNT);

  localparam logic [15:0] IF_TYPE_LOOPBACK = 16'd24;
  localparam logic [15:0] IF_TYPE_TUNNEL   = 16'd131;

  typedef logic [KW_ROW*8-1:0] kw_text_t;
  typedef logic [4:0]          kw_len_t;

  // text is right-justified: the final character sits in the low byte,
  // so byte j of an entry lines up with window slot j (slot 0 newest)
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    kw_text_t'("virtual"),
    kw_text_t'({"vm", "ware"}),
    kw_text_t'({"hyper", "-v"}),
    kw_text_t'("vethernet"),
    kw_text_t'("tap"),
    kw_text_t'("loopback"),
    kw_text_t'("wan miniport"),
    kw_text_t'({"blue", "tooth"}),
    kw_text_t'("vpn"),
    kw_text_t'({"ter", "edo"}),
    kw_text_t'({"v", "box"}),
    kw_text_t'("wi-fi direct"),
    kw_text_t'({"micro", "soft kernel debug"}),
    kw_text_t'("kdnic"),
    kw_text_t'("km-test"),
    kw_text_t'({"virtual", "box"})
  };

  localparam kw_len_t KW_LEN [KW_COUNT] = '{
    5'd7, 5'd6, 5'd7, 5'd9, 5'd3, 5'd8, 5'd12, 5'd9,
    5'd3, 5'd6, 5'd4, 5'd12, 5'd22, 5'd5, 5'd7, 5'd10
  };

  typedef enum logic [1:0] {
    VC_PHYSICAL = 2'd0,
    VC_EXCLUDED = 2'd1,
    VC_EMPTY    = 2'd2,
    VC_KEYWORD  = 2'd3
  } verdict_code_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [15:0] if_type;
  } item_t;

  typedef struct packed {
    logic                likely_physical;
    logic [1:0]          verdict_code;
    logic [KW_IDX_W-1:0] matched_keyword;
  } verdict_t;

  function automatic logic [7:0] kw_byte(input int k, input int pos);
    kw_text_t row;
    row = KW_TEXT[k];
    return row[pos*8 +: 8];
  endfunction

endpackage

>>> rtl/core/vnks_cell.sv
// ----------------------------------------------------------------------------
// vnks_cell
// One window slot: holds a byte, hands it on, and compares its incoming
// byte against every keyword character that falls on this slot.
// ----------------------------------------------------------------------------
module vnks_cell #(
  parameter int POS = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic                        clear,
  input  logic [7:0]                  byte_in,
  output logic [7:0]                  byte_out,
  output logic [vnks_pkg::KW_COUNT-1:0] hit
);
  import vnks_pkg::*;

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // slots past a keyword's length never block it
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      if (POS >= int'(KW_LEN[k]) || POS >= KW_ROW) begin
        hit[k] = 1'b1;
      end else begin
        hit[k] = (byte_in == kw_byte(k, POS));
      end
    end
  end

endmodule

>>> rtl/core/vnks_verdict.sv
// ----------------------------------------------------------------------------
// vnks_verdict
// Forms the verdict from the interface type, the byte flag and the
// keyword mask, with excluded type first and empty description second.
// ----------------------------------------------------------------------------
module vnks_verdict (
  input  logic [15:0]                   if_type,
  input  logic                          any_seen,
  input  logic [vnks_pkg::KW_COUNT-1:0] mask,
  output vnks_pkg::verdict_t            verdict
);
  import vnks_pkg::*;

  logic [KW_IDX_W-1:0] first_idx;

  // lowest set bit wins
  always_comb begin
    first_idx = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (mask[k]) begin
        first_idx = KW_IDX_W'(k);
      end
    end
  end

  always_comb begin
    verdict = '0;
    if (if_type == IF_TYPE_LOOPBACK || if_type == IF_TYPE_TUNNEL) begin
      verdict.verdict_code = VC_EXCLUDED;
    end else if (!any_seen) begin
      verdict.verdict_code = VC_EMPTY;
    end else if (mask != '0) begin
      verdict.verdict_code    = VC_KEYWORD;
      verdict.matched_keyword = first_idx;
    end else begin
      verdict.verdict_code    = VC_PHYSICAL;
      verdict.likely_physical = 1'b1;
    end
  end

endmodule

>>> rtl/core/virtual_nic_keyword_screen_core.sv
// ----------------------------------------------------------------------------
// virtual_nic_keyword_screen_core
// Screens an interface description, one byte per transaction, for
// keywords that mark a virtual adapter, and issues one verdict per
// description.
// ----------------------------------------------------------------------------
// The block takes one byte of description per cycle while item_stall is
// low: the window is a row of WINDOW_BYTES cells that shift on each valid
// byte, and every cell compares its new byte against all sixteen keywords
// in the same cycle, so the sticky keyword mask updates at the rate the
// bytes arrive. The verdict is written into an output register as the
// transaction marked last is taken; the input stalls only while that
// register holds a verdict that downstream is stalling. The window, the
// mask and the byte flag clear as the last transaction is taken, so the
// next description may follow in the very next cycle.
module virtual_nic_keyword_screen_core #(
  parameter int WINDOW_BYTES = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  vnks_pkg::item_t    item,
  output logic               verdict_valid,
  input  logic               verdict_stall,
  output vnks_pkg::verdict_t verdict
);
  import vnks_pkg::*;

  logic                    item_fire;
  logic                    shift;
  logic                    clear;
  logic [7:0]              slot_in  [WINDOW_BYTES];
  logic [7:0]              slot_out [WINDOW_BYTES];
  logic [KW_COUNT-1:0]     slot_hit [WINDOW_BYTES];
  logic [KW_COUNT-1:0]     kw_hit;
  logic [KW_COUNT-1:0]     mask;
  logic [KW_COUNT-1:0]     mask_next;
  logic                    any_seen;
  logic                    any_seen_next;
  verdict_t                verdict_new;

  assign item_stall = verdict_valid && verdict_stall;
  assign item_fire  = item_valid && !item_stall;
  assign shift      = item_fire && item.byte_valid;
  assign clear      = item_fire && item.last_byte;

  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign slot_in[i] = item.char_byte;
    end else begin : g_link
      assign slot_in[i] = slot_out[i-1];
    end

    vnks_cell #(
      .POS (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .clear    (clear),
      .byte_in  (slot_in[i]),
      .byte_out (slot_out[i]),
      .hit      (slot_hit[i])
    );
  end

  // a keyword sits at the tail only if every slot agrees
  always_comb begin
    kw_hit = '1;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      kw_hit = kw_hit & slot_hit[i];
    end
  end

  assign mask_next     = shift ? (mask | kw_hit) : mask;
  assign any_seen_next = any_seen || shift;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      mask     <= '0;
      any_seen <= 1'b0;
    end else begin
      mask     <= mask_next;
      any_seen <= any_seen_next;
    end
  end

  vnks_verdict u_verdict (
    .if_type  (item.if_type),
    .any_seen (any_seen_next),
    .mask     (mask_next),
    .verdict  (verdict_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (clear) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      verdict <= verdict_new;
    end
  end

endmodule
